>>> src/lbs_pkg.sv
// lbs_pkg: shared types, codes and constants for the letterbox nearest-neighbor scaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbs_pkg;

  localparam int SRC_MAX_W_DEF = 256;
  localparam int SRC_MAX_H_DEF = 256;
  localparam int WIN_MAX_DEF   = 2048;

  localparam int IMG_REG_W  = 9;
  localparam int WIN_REG_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam int POS_W      = 11;
  localparam int COLOR_W    = 32;

  localparam logic [IMG_REG_W-1:0] IMG_W_RST = 9'd256;
  localparam logic [IMG_REG_W-1:0] IMG_H_RST = 9'd256;
  localparam logic [WIN_REG_W-1:0] WIN_W_RST = 12'd1280;
  localparam logic [WIN_REG_W-1:0] WIN_H_RST = 12'd800;

  localparam logic [COLOR_W-1:0] COLOR_BORDER     = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_BACKGROUND = 32'hFF20_2020;

  typedef enum logic [1:0] {
    CFG_IMAGE_W,
    CFG_IMAGE_H,
    CFG_WINDOW_W,
    CFG_WINDOW_H
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD,
    CMD_RENDER
  } cmd_e;

  typedef enum logic [1:0] {
    REGION_LOAD,
    REGION_BACKGROUND,
    REGION_IMAGE,
    REGION_BORDER
  } region_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    region_e            region;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/lbs_geom.sv
// lbs_geom: configuration registers and fit-rectangle geometry (size, offsets, pixel count).
// Sequential restoring divider, one quotient bit per cycle. Depends on lbs_pkg.
`default_nettype none

module lbs_geom #(
  parameter int SRC_MAX_W = lbs_pkg::SRC_MAX_W_DEF,
  parameter int SRC_MAX_H = lbs_pkg::SRC_MAX_H_DEF,
  parameter int WIN_MAX   = lbs_pkg::WIN_MAX_DEF,
  parameter int SW        = $clog2(SRC_MAX_W + 1),
  parameter int SH        = $clog2(SRC_MAX_H + 1),
  parameter int WB        = $clog2(WIN_MAX + 1),
  parameter int TW        = $clog2(SRC_MAX_W * SRC_MAX_H + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire lbs_pkg::cfg_idx_e               cfg_idx_i,
  input  wire logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                 busy_o,
  output logic [SW-1:0]                        iw_o,
  output logic [SH-1:0]                        ih_o,
  output logic [WB-1:0]                        ww_o,
  output logic [WB-1:0]                        wh_o,
  output logic [WB-1:0]                        dw_o,
  output logic [WB-1:0]                        dh_o,
  output logic [WB-1:0]                        ox_o,
  output logic [WB-1:0]                        oy_o,
  output logic [TW-1:0]                        total_o
);
  import lbs_pkg::*;

  localparam int MW  = (SW > SH) ? SW : SH;
  localparam int DDW = MW + WB;
  localparam int CW  = $clog2(DDW + 1);

  typedef enum logic [2:0] {
    G_CLAMP,
    G_MUL,
    G_DIV1,
    G_CHK,
    G_DIV2,
    G_SET2,
    G_FIN,
    G_IDLE
  } geom_state_e;

  geom_state_e          state_q;
  logic [IMG_REG_W-1:0] cfg_iw_q, cfg_ih_q;
  logic [WIN_REG_W-1:0] cfg_ww_q, cfg_wh_q;
  logic [SW-1:0]        iw_q;
  logic [SH-1:0]        ih_q;
  logic [WB-1:0]        ww_q, wh_q, dw_q, dh_q, ox_q, oy_q;
  logic [TW-1:0]        total_q;
  logic [DDW-1:0]       quo_q, quo_d;
  logic [MW-1:0]        rem_q, rem_d, dvs_q;
  logic [CW-1:0]        cnt_q;

  logic [31:0]          iw_x, ih_x, ww_x, wh_x;
  logic [SW-1:0]        iw_c;
  logic [SH-1:0]        ih_c;
  logic [WB-1:0]        ww_c, wh_c;
  logic [MW:0]          rem_sh;
  logic                 ge;

  always_comb begin
    iw_x = 32'(cfg_iw_q);
    ih_x = 32'(cfg_ih_q);
    ww_x = 32'(cfg_ww_q);
    wh_x = 32'(cfg_wh_q);
    if (iw_x == 32'd0) iw_x = 32'd1;
    else if (iw_x > 32'(SRC_MAX_W)) iw_x = 32'(SRC_MAX_W);
    if (ih_x == 32'd0) ih_x = 32'd1;
    else if (ih_x > 32'(SRC_MAX_H)) ih_x = 32'(SRC_MAX_H);
    if (ww_x == 32'd0) ww_x = 32'd1;
    else if (ww_x > 32'(WIN_MAX)) ww_x = 32'(WIN_MAX);
    if (wh_x == 32'd0) wh_x = 32'd1;
    else if (wh_x > 32'(WIN_MAX)) wh_x = 32'(WIN_MAX);
    iw_c = SW'(iw_x);
    ih_c = SH'(ih_x);
    ww_c = WB'(ww_x);
    wh_c = WB'(wh_x);
  end

  // one restoring step: shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q, quo_q[DDW-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_d  = ge ? MW'(rem_sh - {1'b0, dvs_q}) : MW'(rem_sh);
    quo_d  = {quo_q[DDW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= G_CLAMP;
      cfg_iw_q <= IMG_W_RST;
      cfg_ih_q <= IMG_H_RST;
      cfg_ww_q <= WIN_W_RST;
      cfg_wh_q <= WIN_H_RST;
      iw_q     <= '0;
      ih_q     <= '0;
      ww_q     <= '0;
      wh_q     <= '0;
      dw_q     <= '0;
      dh_q     <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
      total_q  <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      dvs_q    <= '0;
      cnt_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_W:  cfg_iw_q <= cfg_data_i[IMG_REG_W-1:0];
        CFG_IMAGE_H:  cfg_ih_q <= cfg_data_i[IMG_REG_W-1:0];
        CFG_WINDOW_W: cfg_ww_q <= cfg_data_i[WIN_REG_W-1:0];
        CFG_WINDOW_H: cfg_wh_q <= cfg_data_i[WIN_REG_W-1:0];
        default:      cfg_iw_q <= cfg_iw_q;
      endcase
      state_q <= G_CLAMP;
    end else begin
      unique case (state_q)
        G_CLAMP: begin
          iw_q    <= iw_c;
          ih_q    <= ih_c;
          ww_q    <= ww_c;
          wh_q    <= wh_c;
          state_q <= G_MUL;
        end
        G_MUL: begin
          quo_q   <= DDW'(ih_q) * DDW'(ww_q);
          total_q <= TW'(iw_q) * TW'(ih_q);
          rem_q   <= '0;
          dvs_q   <= MW'(iw_q);
          cnt_q   <= CW'(DDW);
          state_q <= G_DIV1;
        end
        G_DIV1, G_DIV2: begin
          quo_q <= quo_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= (state_q == G_DIV1) ? G_CHK : G_SET2;
          end
        end
        G_CHK: begin
          if (quo_q > DDW'(wh_q)) begin
            dh_q    <= wh_q;
            quo_q   <= DDW'(iw_q) * DDW'(wh_q);
            rem_q   <= '0;
            dvs_q   <= MW'(ih_q);
            cnt_q   <= CW'(DDW);
            state_q <= G_DIV2;
          end else begin
            dw_q    <= ww_q;
            dh_q    <= (quo_q == '0) ? WB'(1) : WB'(quo_q);
            state_q <= G_FIN;
          end
        end
        G_SET2: begin
          dw_q    <= (quo_q == '0) ? WB'(1) : WB'(quo_q);
          state_q <= G_FIN;
        end
        G_FIN: begin
          ox_q    <= (ww_q - dw_q) >> 1;
          oy_q    <= (wh_q - dh_q) >> 1;
          state_q <= G_IDLE;
        end
        G_IDLE: begin
          state_q <= G_IDLE;
        end
        default: begin
          state_q <= G_CLAMP;
        end
      endcase
    end
  end

  assign busy_o  = (state_q != G_IDLE);
  assign iw_o    = iw_q;
  assign ih_o    = ih_q;
  assign ww_o    = ww_q;
  assign wh_o    = wh_q;
  assign dw_o    = dw_q;
  assign dh_o    = dh_q;
  assign ox_o    = ox_q;
  assign oy_o    = oy_q;
  assign total_o = total_q;

endmodule

`default_nettype wire

>>> src/lbs_div_pipe.sv
// lbs_div_pipe: pipelined restoring divider for both axes, one quotient bit per stage.
// Carries item sideband alongside; stalls as a whole on adv_i. Depends on lbs_pkg.
`default_nettype none

module lbs_div_pipe #(
  parameter int QW     = 9,
  parameter int DVW    = 21,
  parameter int DSW    = 12,
  parameter int SIDE_W = 50
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic [DVW-1:0]    dvx_i,
  input  wire logic [DVW-1:0]    dvy_i,
  input  wire logic [DSW-1:0]    dsx_i,
  input  wire logic [DSW-1:0]    dsy_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [QW-1:0]          qx_o,
  output logic [QW-1:0]          qy_o,
  output logic [SIDE_W-1:0]      side_o
);
  import lbs_pkg::*;

  localparam int EW = DVW + QW;

  logic [QW-1:0]     v_q;
  logic [DVW-1:0]    rx_q [QW];
  logic [DVW-1:0]    ry_q [QW];
  logic [QW-1:0]     qx_q [QW];
  logic [QW-1:0]     qy_q [QW];
  logic [SIDE_W-1:0] sd_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic              v_in;
    logic [DVW-1:0]    rx_in, ry_in, rx_d, ry_d;
    logic [QW-1:0]     qx_in, qy_in, qx_d, qy_d;
    logic [SIDE_W-1:0] sd_in;
    logic [EW-1:0]     tx, ty;
    logic              gx, gy;

    if (k == 0) begin : g_head
      assign v_in  = valid_i;
      assign rx_in = dvx_i;
      assign ry_in = dvy_i;
      assign qx_in = '0;
      assign qy_in = '0;
      assign sd_in = side_i;
    end else begin : g_body
      assign v_in  = v_q[k-1];
      assign rx_in = rx_q[k-1];
      assign ry_in = ry_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
      assign sd_in = sd_q[k-1];
    end

    always_comb begin
      tx   = EW'(dsx_i) << B;
      ty   = EW'(dsy_i) << B;
      gx   = (EW'(rx_in) >= tx);
      gy   = (EW'(ry_in) >= ty);
      rx_d = gx ? DVW'(EW'(rx_in) - tx) : rx_in;
      ry_d = gy ? DVW'(EW'(ry_in) - ty) : ry_in;
      qx_d = qx_in;
      qy_d = qy_in;
      qx_d[B] = gx;
      qy_d[B] = gy;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rx_q[k] <= rx_d;
        ry_q[k] <= ry_d;
        qx_q[k] <= qx_d;
        qy_q[k] <= qy_d;
        sd_q[k] <= sd_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign qx_o    = qx_q[QW-1];
  assign qy_o    = qy_q[QW-1];
  assign side_o  = sd_q[QW-1];

endmodule

`default_nettype wire

>>> src/lbs_frame_store.sv
// lbs_frame_store: single-port source frame memory, registered read data.
// Write or read one entry per enabled cycle. Depends on lbs_pkg.
`default_nettype none

module lbs_frame_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                addr_i,
  input  wire logic [lbs_pkg::COLOR_W-1:0]  wdata_i,
  output logic [lbs_pkg::COLOR_W-1:0]       rdata_o
);
  import lbs_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rd_q <= mem[addr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

>>> src/letterbox_nearest_scaler.sv
// letterbox_nearest_scaler: top level; load/render pipeline around the frame store.
// Uses lbs_pkg, lbs_geom, lbs_div_pipe, lbs_frame_store.
//
//   channel  | direction | handshake               | payload
//   in       | input     | in_valid_i / in_ready_o | in_item_i  (lbs_pkg::in_item_t)
//   out      | output    | out_valid_o/ out_ready_i| out_item_o (lbs_pkg::out_item_t)
//   cfg      | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One item per cycle while the pipeline advances and the geometry unit is idle.
// After reset and after every register write, in_ready_o stays low while the
// geometry unit divides serially. The pipeline stalls only when its last stage
// holds an item and the output register is full and not taken. Frame store
// contents are undefined until loaded.
`default_nettype none

module letterbox_nearest_scaler #(
  parameter int SRC_MAX_W = lbs_pkg::SRC_MAX_W_DEF,
  parameter int SRC_MAX_H = lbs_pkg::SRC_MAX_H_DEF,
  parameter int WIN_MAX   = lbs_pkg::WIN_MAX_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lbs_pkg::in_item_t               in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lbs_pkg::out_item_t                   out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire lbs_pkg::cfg_idx_e               cfg_idx_i,
  input  wire logic [lbs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lbs_pkg::*;

  localparam int SW     = $clog2(SRC_MAX_W + 1);
  localparam int SH     = $clog2(SRC_MAX_H + 1);
  localparam int MW     = (SW > SH) ? SW : SH;
  localparam int MAXS   = (SRC_MAX_W > SRC_MAX_H) ? SRC_MAX_W : SRC_MAX_H;
  localparam int QW     = $clog2(MAXS + 1);
  localparam int WB     = $clog2(WIN_MAX + 1);
  localparam int XW     = (WB > POS_W) ? WB : POS_W;
  localparam int DVW    = XW + MW;
  localparam int DEPTH  = SRC_MAX_W * SRC_MAX_H;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW     = $clog2(DEPTH + 1);
  localparam int SIDE_W = 2 + COLOR_W + AW;
  localparam int IXW    = QW + SW + 1;

  logic          busy;
  logic [SW-1:0] iw;
  logic [SH-1:0] ih;
  logic [WB-1:0] ww, wh, dw, dh, ox, oy;
  logic [TW-1:0] total;

  lbs_geom #(
    .SRC_MAX_W (SRC_MAX_W),
    .SRC_MAX_H (SRC_MAX_H),
    .WIN_MAX   (WIN_MAX),
    .SW        (SW),
    .SH        (SH),
    .WB        (WB),
    .TW        (TW)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .iw_o       (iw),
    .ih_o       (ih),
    .ww_o       (ww),
    .wh_o       (wh),
    .dw_o       (dw),
    .dh_o       (dh),
    .ox_o       (ox),
    .oy_o       (oy),
    .total_o    (total)
  );

  logic adv, accept, out_load;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vd;

  // stage 1: captured item
  cmd_e               cmd1_q;
  logic [COLOR_W-1:0] col1_q;
  logic [POS_W-1:0]   px1_q, py1_q;
  logic [AW-1:0]      ptr1_q, load_ptr_q;
  logic [AW:0]        ptr_nx;

  // stage 2: classified item
  region_e            reg2_q, reg2_d;
  logic [COLOR_W-1:0] col2_q;
  logic [AW-1:0]      ptr2_q;
  logic [XW-1:0]      x2_q, y2_q, x_d, y_d;

  // stage 3: dividends
  logic [DVW-1:0]     dvx3_q, dvy3_q;
  logic [SIDE_W-1:0]  side3_q, side_d;

  // divider output
  logic [QW-1:0]      sx, sy;
  region_e            reg_d;
  logic [COLOR_W-1:0] col_d;
  logic [AW-1:0]      ptr_d;
  logic [IXW-1:0]     idx;

  // stage 4: memory access
  logic               we4_q;
  logic [AW-1:0]      addr4_q;
  logic [COLOR_W-1:0] col4_q;
  region_e            reg4_q;

  // stage 5: read data
  region_e            reg5_q;
  logic [COLOR_W-1:0] rdata;

  logic               out_v_q;
  out_item_t          out_q, out_d;

  assign adv        = !v5_q || !out_v_q || out_ready_i;
  assign in_ready_o = adv && !busy && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = v5_q && (!out_v_q || out_ready_i);
  assign ptr_nx     = (AW + 1)'(load_ptr_q) + (AW + 1)'(1);

  always_comb begin
    logic [XW-1:0] px, py, wwe, whe, oxe, oye, dwe, dhe;
    logic          bg, edge_hit;
    px  = XW'(px1_q);
    py  = XW'(py1_q);
    wwe = XW'(ww);
    whe = XW'(wh);
    oxe = XW'(ox);
    oye = XW'(oy);
    dwe = XW'(dw);
    dhe = XW'(dh);
    x_d = px - oxe;
    y_d = py - oye;
    bg  = (px >= wwe) || (py >= whe) || (px < oxe) || (py < oye) ||
          (x_d >= dwe) || (y_d >= dhe);
    edge_hit = (x_d == '0) || (y_d == '0) ||
               (x_d == dwe - XW'(1)) || (y_d == dhe - XW'(1));
    if (cmd1_q == CMD_LOAD) reg2_d = REGION_LOAD;
    else if (bg)            reg2_d = REGION_BACKGROUND;
    else if (edge_hit)      reg2_d = REGION_BORDER;
    else                    reg2_d = REGION_IMAGE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (accept && (in_item_i.cmd == CMD_LOAD)) begin
        load_ptr_q <= (32'(ptr_nx) >= 32'(total)) ? '0 : AW'(ptr_nx);
      end
      if (adv) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= vd;
        v5_q <= v4_q;
      end
      if (out_load)         out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q  <= in_item_i.cmd;
      col1_q  <= {in_item_i.alpha, in_item_i.red, in_item_i.green, in_item_i.blue};
      px1_q   <= in_item_i.pos_x;
      py1_q   <= in_item_i.pos_y;
      ptr1_q  <= load_ptr_q;

      reg2_q  <= reg2_d;
      col2_q  <= col1_q;
      ptr2_q  <= ptr1_q;
      x2_q    <= x_d;
      y2_q    <= y_d;

      dvx3_q  <= DVW'(x2_q) * DVW'(iw);
      dvy3_q  <= DVW'(y2_q) * DVW'(ih);
      side3_q <= {reg2_q, col2_q, ptr2_q};

      we4_q   <= (reg_d == REGION_LOAD);
      addr4_q <= (reg_d == REGION_LOAD) ? ptr_d : AW'(idx);
      col4_q  <= col_d;
      reg4_q  <= reg_d;

      reg5_q  <= reg4_q;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  lbs_div_pipe #(
    .QW     (QW),
    .DVW    (DVW),
    .DSW    (WB),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v3_q),
    .dvx_i   (dvx3_q),
    .dvy_i   (dvy3_q),
    .dsx_i   (dw),
    .dsy_i   (dh),
    .side_i  (side3_q),
    .valid_o (vd),
    .qx_o    (sx),
    .qy_o    (sy),
    .side_o  (side_d)
  );

  assign reg_d = region_e'(side_d[SIDE_W-1 -: 2]);
  assign col_d = side_d[AW +: COLOR_W];
  assign ptr_d = side_d[AW-1:0];
  assign idx   = IXW'(sy) * IXW'(iw) + IXW'(sx);

  lbs_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (v4_q && we4_q),
    .addr_i  (addr4_q),
    .wdata_i (col4_q),
    .rdata_o (rdata)
  );

  always_comb begin
    out_d.region = reg5_q;
    case (reg5_q)
      REGION_LOAD:       out_d.pixel_color = '0;
      REGION_BACKGROUND: out_d.pixel_color = COLOR_BACKGROUND;
      REGION_BORDER:     out_d.pixel_color = COLOR_BORDER;
      REGION_IMAGE:      out_d.pixel_color = rdata;
      default:           out_d.pixel_color = COLOR_BACKGROUND;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
